// File: design/lookat_view_matrix_top_macros.svh
// ----------------------------------------------------------------------------
// View matrix assertion macros
// Shared property wrappers for the view matrix port checks.
// ----------------------------------------------------------------------------
`ifndef LOOKAT_VIEW_MATRIX_TOP_MACROS_SVH
`define LOOKAT_VIEW_MATRIX_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define LVM_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("view matrix check failed");

// next-cycle implication, masked during reset
`define LVM_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("view matrix check failed");

// next-cycle implication that also holds across reset
`define LVM_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("view matrix reset check failed");

`endif

// File: design/lvm_pkg.sv
// ----------------------------------------------------------------------------
// lvm_pkg
// Shared constants and types of the look-at view matrix block.
// ----------------------------------------------------------------------------
package lvm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } lvm_qstat_t;

endpackage

// File: design/lookat_view_matrix_top.sv
// ----------------------------------------------------------------------------
// lookat_view_matrix_top
// Look-at view matrix in signed fixed point, one command in, four rows out.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Each command yields
// four rows, row 0 to row 3, on consecutive cycles, each marked by out_valid
// for one cycle; the receiver cannot stall, so take every row as it comes.
// While a command occupies the engine, its time goes to the shared bit-serial
// square root (32 steps per normalize), the restoring divider (FRAC_BITS + 2
// steps plus a setup step per component) and the pre-normalize shifts, run
// once for the backward axis and once for the right axis. A degenerate
// command is shorter: both normalizes are skipped when eye equals target,
// and the right-axis normalize is skipped when the cross product is zero. A
// two-entry queue sits between the command side and the engine, so two
// commands can wait while one runs; busy is high only while that queue is
// full.
// ----------------------------------------------------------------------------
module lookat_view_matrix_top #(
  parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = lvm_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [WORD_BITS-1:0]  in_eye_x,
  input  logic signed [WORD_BITS-1:0]  in_eye_y,
  input  logic signed [WORD_BITS-1:0]  in_eye_z,
  input  logic signed [WORD_BITS-1:0]  in_target_x,
  input  logic signed [WORD_BITS-1:0]  in_target_y,
  input  logic signed [WORD_BITS-1:0]  in_target_z,
  input  logic signed [WORD_BITS-1:0]  in_up_x,
  input  logic signed [WORD_BITS-1:0]  in_up_y,
  input  logic signed [WORD_BITS-1:0]  in_up_z,
  output logic                         out_valid,
  output logic [1:0]                   out_row_index,
  output logic signed [WORD_BITS-1:0]  out_elem0,
  output logic signed [WORD_BITS-1:0]  out_elem1,
  output logic signed [WORD_BITS-1:0]  out_elem2,
  output logic signed [WORD_BITS-1:0]  out_elem3,
  output logic                         out_degenerate,
  output logic                         out_last_row
);
  import lvm_pkg::*;

  // queue entry: eye, eye - target, up, zero-length flag
  localparam int EW = 9*WORD_BITS + 4;

  logic          push;
  logic          pop;
  logic [EW-1:0] entry;
  logic [EW-1:0] head;
  lvm_qstat_t    qst;

  // front: command transfer and view vector
  lvm_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .start    (start),
    .busy     (busy),
    .eye_x    (in_eye_x),
    .eye_y    (in_eye_y),
    .eye_z    (in_eye_z),
    .target_x (in_target_x),
    .target_y (in_target_y),
    .target_z (in_target_z),
    .up_x     (in_up_x),
    .up_y     (in_up_y),
    .up_z     (in_up_z),
    .qst      (qst),
    .push     (push),
    .entry    (entry)
  );

  // decoupling queue
  lvm_fifo #(
    .DW (EW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (entry),
    .pop   (pop),
    .rdata (head),
    .qst   (qst)
  );

  // back: axes, dot products, row output
  lvm_back #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .qst            (qst),
    .q_data         (head),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_row_index  (out_row_index),
    .out_elem0      (out_elem0),
    .out_elem1      (out_elem1),
    .out_elem2      (out_elem2),
    .out_elem3      (out_elem3),
    .out_degenerate (out_degenerate),
    .out_last_row   (out_last_row)
  );

endmodule

// File: design/lvm_front.sv
// ----------------------------------------------------------------------------
// lvm_front
// Takes one command, forms eye - target and flags a zero-length view vector.
// ----------------------------------------------------------------------------
module lvm_front #(
  parameter int WORD_BITS = lvm_pkg::WORD_BITS_DEF
) (
  input  logic                          start,
  output logic                          busy,
  input  logic signed [WORD_BITS-1:0]   eye_x,
  input  logic signed [WORD_BITS-1:0]   eye_y,
  input  logic signed [WORD_BITS-1:0]   eye_z,
  input  logic signed [WORD_BITS-1:0]   target_x,
  input  logic signed [WORD_BITS-1:0]   target_y,
  input  logic signed [WORD_BITS-1:0]   target_z,
  input  logic signed [WORD_BITS-1:0]   up_x,
  input  logic signed [WORD_BITS-1:0]   up_y,
  input  logic signed [WORD_BITS-1:0]   up_z,
  input  lvm_pkg::lvm_qstat_t           qst,
  output logic                          push,
  output logic [9*WORD_BITS+3:0]        entry
);
  import lvm_pkg::*;

  localparam int W = WORD_BITS;

  logic signed [W:0] d_x, d_y, d_z;
  logic              dzero;

  assign busy  = qst.full;
  assign push  = start && !qst.full;

  assign d_x   = (W+1)'(eye_x) - (W+1)'(target_x);
  assign d_y   = (W+1)'(eye_y) - (W+1)'(target_y);
  assign d_z   = (W+1)'(eye_z) - (W+1)'(target_z);
  assign dzero = (eye_x == target_x) && (eye_y == target_y) && (eye_z == target_z);

  assign entry = {dzero, up_z, up_y, up_x, d_z, d_y, d_x, eye_z, eye_y, eye_x};

endmodule

// File: design/lvm_fifo.sv
// ----------------------------------------------------------------------------
// lvm_fifo
// Two-entry queue between the command front and the matrix engine.
// ----------------------------------------------------------------------------
module lvm_fifo #(
  parameter int DW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DW-1:0]        wdata,
  input  logic                 pop,
  output logic [DW-1:0]        rdata,
  output lvm_pkg::lvm_qstat_t  qst
);
  import lvm_pkg::*;

  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign qst.full  = (cnt_r == 2'd2);
  assign qst.empty = (cnt_r == 2'd0);
  assign rdata     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// File: design/lvm_back.sv
// ----------------------------------------------------------------------------
// lvm_back
// Matrix engine: shared multiplier, bit-serial square root and divider,
// sequenced per item; emits the four rows.
// ----------------------------------------------------------------------------
module lvm_back #(
  parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = lvm_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lvm_pkg::lvm_qstat_t          qst,
  input  logic [9*WORD_BITS+3:0]       q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  output logic [1:0]                   out_row_index,
  output logic signed [WORD_BITS-1:0]  out_elem0,
  output logic signed [WORD_BITS-1:0]  out_elem1,
  output logic signed [WORD_BITS-1:0]  out_elem2,
  output logic signed [WORD_BITS-1:0]  out_elem3,
  output logic                         out_degenerate,
  output logic                         out_last_row
);
  import lvm_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int W   = WORD_BITS;
  localparam int VW  = (W + 1 > F + 34) ? W + 1 : F + 34;  // vector being normalized
  localparam int AXW = F + 3;                              // unit axis component
  localparam int AW  = (W > 32) ? W : 32;                  // multiplier A side
  localparam int PW  = AW + 32;
  localparam int ACW = PW + 2;
  localparam int NW  = F + 33;                             // divider numerator
  localparam int QW  = F + 2;                              // quotient

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NMAG = 4'd1;
  localparam logic [3:0] S_NSHR = 4'd2;
  localparam logic [3:0] S_NSHL = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_DIVI = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_UPSH = 4'd7;
  localparam logic [3:0] S_MAC  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic [1:0] M_SQ  = 2'd0;  // sum of squares
  localparam logic [1:0] M_CR  = 2'd1;  // cross(up, b)
  localparam logic [1:0] M_UV  = 2'd2;  // cross(b, r)
  localparam logic [1:0] M_DOT = 2'd3;  // axis dot eye

  function automatic logic [1:0] nx1(input logic [1:0] g);
    unique case (g)
      2'd0:    nx1 = 2'd1;
      2'd1:    nx1 = 2'd2;
      default: nx1 = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] nx2(input logic [1:0] g);
    unique case (g)
      2'd0:    nx2 = 2'd2;
      2'd1:    nx2 = 2'd0;
      default: nx2 = 2'd1;
    endcase
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [ACW-1:0] x);
    logic signed [ACW-1:0] hi;
    logic signed [ACW-1:0] lo;
    hi = {{(ACW-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if (x > hi)      sat_w = hi[W-1:0];
    else if (x < lo) sat_w = lo[W-1:0];
    else             sat_w = x[W-1:0];
  endfunction

  // floor((x + half) / 2^F)
  function automatic logic signed [ACW-1:0] rnd(input logic signed [ACW-1:0] x);
    logic signed [ACW-1:0] t;
    t = x + ({{(ACW-1){1'b0}}, 1'b1} <<< (F-1));
    rnd = t >>> F;
  endfunction

  // queue head fields
  logic signed [W-1:0] q_eye [3];
  logic signed [W:0]   q_d   [3];
  logic signed [W-1:0] q_up  [3];
  logic                q_dzero;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign q_eye[i] = q_data[i*W +: W];
    assign q_d[i]   = q_data[3*W + i*(W+1) +: W+1];
    assign q_up[i]  = q_data[6*W+3 + i*W +: W];
  end
  assign q_dzero = q_data[9*W+3];

  logic [3:0]            st_r;
  logic [1:0]            mode_r, grp_r, trm_r, cidx_r, row_r;
  logic                  ph_r, tgt_rt_r, degen_r;
  logic signed [ACW-1:0] acc_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [W-1:0]   eye_r   [3];
  logic signed [W-1:0]   upraw_r [3];
  logic signed [31:0]    up_r    [3];
  logic signed [VW-1:0]  vec_r   [3];
  logic [VW-1:0]         m_r     [3];
  logic signed [AXW-1:0] bk_r    [3];
  logic signed [AXW-1:0] rt_r    [3];
  logic signed [AXW-1:0] uv_r    [3];
  logic signed [W-1:0]   dot_r   [3];
  logic [63:0]           rem_r, res_r, bit_r;
  logic [30:0]           len_r;
  logic [NW-1:0]         num_r, dvs_r;
  logic [QW-1:0]         q_r;
  logic [4:0]            cnt_r;

  logic                  out_valid_r, out_degen_r, out_last_r;
  logic [1:0]            out_row_r;
  logic signed [W-1:0]   out_e0_r, out_e1_r, out_e2_r, out_e3_r;

  // magnitude helpers
  logic [VW-1:0]         vmag  [3];
  logic [VW-1:0]         upmag [3];
  logic [VW-1:0]         m_or;
  logic signed [VW-1:0]  upx   [3];

  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign vmag[i]  = vec_r[i][VW-1] ? $unsigned(-vec_r[i]) : $unsigned(vec_r[i]);
    assign upx[i]   = VW'(upraw_r[i]);
    assign upmag[i] = upx[i][VW-1] ? $unsigned(-upx[i]) : $unsigned(upx[i]);
  end
  assign m_or = m_r[0] | m_r[1] | m_r[2];

  // shared multiplier operands
  logic signed [AW-1:0]  opa;
  logic signed [31:0]    opb;
  logic                  opneg;
  logic [1:0]            i1, i2, lastt, lastg;
  logic signed [ACW-1:0] padd, accn, accr;

  assign i1 = nx1(grp_r);
  assign i2 = nx2(grp_r);

  always_comb begin
    opa   = '0;
    opb   = '0;
    opneg = 1'b0;
    unique case (mode_r)
      M_SQ: begin
        opa = AW'($signed({1'b0, m_r[trm_r][29:0]}));
        opb = {2'b00, m_r[trm_r][29:0]};
      end
      M_CR: begin
        opneg = (trm_r == 2'd1);
        opa   = (trm_r == 2'd0) ? AW'(up_r[i1]) : AW'(up_r[i2]);
        opb   = (trm_r == 2'd0) ? 32'(bk_r[i2]) : 32'(bk_r[i1]);
      end
      M_UV: begin
        opneg = (trm_r == 2'd1);
        opa   = (trm_r == 2'd0) ? AW'(bk_r[i1]) : AW'(bk_r[i2]);
        opb   = (trm_r == 2'd0) ? 32'(rt_r[i2]) : 32'(rt_r[i1]);
      end
      default: begin
        opa = AW'(eye_r[trm_r]);
        unique case (grp_r)
          2'd0:    opb = 32'(rt_r[trm_r]);
          2'd1:    opb = 32'(uv_r[trm_r]);
          default: opb = 32'(bk_r[trm_r]);
        endcase
      end
    endcase
  end

  assign lastt = (mode_r == M_SQ || mode_r == M_DOT) ? 2'd2 : 2'd1;
  assign lastg = (mode_r == M_SQ) ? 2'd0 : 2'd2;
  assign padd  = ACW'(prod_r);
  assign accn  = ((trm_r == 2'd0) ? '0 : acc_r) + (opneg ? -padd : padd);
  assign accr  = rnd(accn);

  // square root step
  logic [63:0] rb, res_nxt;
  logic        sq_ge;
  assign rb      = res_r + bit_r;
  assign sq_ge   = (rem_r >= rb);
  assign res_nxt = sq_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  // divider step
  logic                  dv_ge;
  logic [QW-1:0]         q_nxt;
  logic signed [AXW-1:0] qpos, axis_nxt;
  assign dv_ge    = (num_r >= dvs_r);
  assign q_nxt    = {q_r[QW-2:0], dv_ge};
  assign qpos     = $signed({1'b0, q_nxt});
  assign axis_nxt = vec_r[cidx_r][VW-1] ? -qpos : qpos;

  assign q_pop = (st_r == S_IDLE) && !qst.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      ph_r        <= 1'b0;
    end else begin
      out_valid_r <= (st_r == S_OUT);
      unique case (st_r)
        S_IDLE: begin
          if (!qst.empty) begin
            for (int i = 0; i < 3; i++) begin
              eye_r[i]   <= q_eye[i];
              upraw_r[i] <= q_up[i];
              vec_r[i]   <= VW'(q_d[i]);
              if (q_dzero) begin
                m_r[i] <= VW'(q_up[i][W-1] ? $unsigned(-(VW'(q_up[i])))
                                           : $unsigned(VW'(q_up[i])));
              end else begin
                m_r[i] <= q_d[i][W] ? VW'($unsigned(-q_d[i])) : VW'($unsigned(q_d[i]));
              end
            end
            tgt_rt_r <= 1'b0;
            degen_r  <= q_dzero;
            if (q_dzero) begin
              for (int i = 0; i < 3; i++) bk_r[i] <= '0;
              st_r <= S_UPSH;
            end else begin
              st_r <= S_NSHR;
            end
          end
        end
        S_NMAG: begin
          if (vmag[0] == '0 && vmag[1] == '0 && vmag[2] == '0) begin
            for (int i = 0; i < 3; i++) rt_r[i] <= '0;
            degen_r <= 1'b1;
            mode_r  <= M_UV;
            grp_r   <= 2'd0;
            trm_r   <= 2'd0;
            ph_r    <= 1'b0;
            st_r    <= S_MAC;
          end else begin
            for (int i = 0; i < 3; i++) m_r[i] <= vmag[i];
            st_r <= S_NSHR;
          end
        end
        S_NSHR: begin
          if (|m_or[VW-1:30]) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else begin
            st_r <= S_NSHL;
          end
        end
        S_NSHL: begin
          if (!(|m_or[VW-1:29])) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            mode_r <= M_SQ;
            grp_r  <= 2'd0;
            trm_r  <= 2'd0;
            ph_r   <= 1'b0;
            st_r   <= S_MAC;
          end
        end
        S_SQRT: begin
          if (sq_ge) rem_r <= rem_r - rb;
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            len_r  <= res_nxt[30:0];
            cidx_r <= 2'd0;
            st_r   <= S_DIVI;
          end
        end
        S_DIVI: begin
          num_r <= (NW'(m_r[cidx_r][29:0]) << F) + NW'(len_r >> 1);
          dvs_r <= NW'(len_r) << (F + 1);
          q_r   <= '0;
          cnt_r <= 5'd0;
          st_r  <= S_DIV;
        end
        S_DIV: begin
          if (dv_ge) num_r <= num_r - dvs_r;
          dvs_r <= dvs_r >> 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(QW - 1)) begin
            if (tgt_rt_r) rt_r[cidx_r] <= axis_nxt;
            else          bk_r[cidx_r] <= axis_nxt;
            if (cidx_r == 2'd2) begin
              if (!tgt_rt_r) begin
                for (int i = 0; i < 3; i++) m_r[i] <= upmag[i];
                st_r <= S_UPSH;
              end else begin
                mode_r <= M_UV;
                grp_r  <= 2'd0;
                trm_r  <= 2'd0;
                ph_r   <= 1'b0;
                st_r   <= S_MAC;
              end
            end else begin
              cidx_r <= cidx_r + 2'd1;
              st_r   <= S_DIVI;
            end
          end
        end
        S_UPSH: begin
          if (|m_or[VW-1:30]) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              up_r[i] <= upraw_r[i][W-1] ? -$signed({2'b00, m_r[i][29:0]})
                                         : $signed({2'b00, m_r[i][29:0]});
            end
            mode_r <= M_CR;
            grp_r  <= 2'd0;
            trm_r  <= 2'd0;
            ph_r   <= 1'b0;
            st_r   <= S_MAC;
          end
        end
        S_MAC: begin
          if (!ph_r) begin
            prod_r <= opa * opb;
            ph_r   <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            if (trm_r != lastt) begin
              acc_r <= accn;
              trm_r <= trm_r + 2'd1;
            end else begin
              trm_r <= 2'd0;
              // cross(b, r) done: dot products restart at group 0
              grp_r <= (mode_r == M_UV && grp_r == lastg) ? 2'd0 : grp_r + 2'd1;
              unique case (mode_r)
                M_SQ: begin
                  rem_r <= accn[63:0];
                  res_r <= '0;
                  bit_r <= 64'd1 << 62;
                  cnt_r <= 5'd0;
                  st_r  <= S_SQRT;
                end
                M_CR: begin
                  vec_r[grp_r] <= accn[VW-1:0];
                  if (grp_r == lastg) begin
                    tgt_rt_r <= 1'b1;
                    st_r     <= S_NMAG;
                  end
                end
                M_UV: begin
                  uv_r[grp_r] <= accr[AXW-1:0];
                  if (grp_r == lastg) begin
                    mode_r <= M_DOT;
                  end
                end
                default: begin
                  dot_r[grp_r] <= sat_w(-accr);
                  if (grp_r == lastg) begin
                    row_r <= 2'd0;
                    st_r  <= S_OUT;
                  end
                end
              endcase
            end
          end
        end
        S_OUT: begin
          out_row_r   <= row_r;
          out_degen_r <= degen_r;
          out_last_r  <= (row_r == 2'd3);
          if (row_r == 2'd3) begin
            out_e0_r <= dot_r[0];
            out_e1_r <= dot_r[1];
            out_e2_r <= dot_r[2];
            out_e3_r <= sat_w({{(ACW-1){1'b0}}, 1'b1} <<< F);
            st_r     <= S_IDLE;
          end else begin
            out_e0_r <= sat_w(ACW'(rt_r[row_r]));
            out_e1_r <= sat_w(ACW'(uv_r[row_r]));
            out_e2_r <= sat_w(ACW'(bk_r[row_r]));
            out_e3_r <= '0;
          end
          row_r <= row_r + 2'd1;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_index  = out_row_r;
  assign out_elem0      = out_e0_r;
  assign out_elem1      = out_e1_r;
  assign out_elem2      = out_e2_r;
  assign out_elem3      = out_e3_r;
  assign out_degenerate = out_degen_r;
  assign out_last_row   = out_last_r;

endmodule

// File: design/lvm_chk.sv
// ----------------------------------------------------------------------------
// lvm_chk
// Port-level checks of the row sequence, bound to the top level.
// ----------------------------------------------------------------------------
`include "lookat_view_matrix_top_macros.svh"

module lvm_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_row_index,
  input logic       out_degenerate,
  input logic       out_last_row
);

  `LVM_IMP(a_row_start, out_valid && !$past(out_valid), out_row_index == 2'd0)
  `LVM_NXT(a_row_seq, out_valid && !out_last_row, out_valid && (out_row_index == $past(out_row_index) + 2'd1))
  `LVM_NXT(a_degen_hold, out_valid && !out_last_row, out_degenerate == $past(out_degenerate))
  `LVM_RST(a_reset_quiet, !rst_n, !out_valid && !busy)

endmodule

bind lookat_view_matrix_top lvm_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_row_index  (out_row_index),
  .out_degenerate (out_degenerate),
  .out_last_row   (out_last_row)
);
